// File: sv/shbm_pkg.sv
// Package for the streaming histogram with bin merging.
// Widths, operation and register codes, and formula codes; no dependencies.
`default_nettype none

package shbm_pkg;

   // Table geometry and value formats.
   localparam int MAX_BINS   = 64;
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = 32;
   localparam int DEPTH      = MAX_BINS + 1;
   localparam int BIN_W      = $clog2(DEPTH + 1);
   localparam int IDX_IN_W   = 6;
   localparam int RAW_W      = 48;
   localparam int NORM_W     = 32;
   localparam int PROD_W     = 2 * VAL_W;

   // Configuration port.
   localparam int CAP_W      = 7;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Shared divider: the widest dividend is a 65-bit sum shifted by two fraction widths.
   localparam int DIV_N_W    = 2 * CNT_W + 1 + 2 * FRAC_BITS;
   localparam int DIV_D_W    = 2 * VAL_W;
   localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

   // Request operations.
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 1'd1;

   // Density formula codes; the unused code behaves as the simple average.
   localparam logic [MODE_W-1:0] MODE_SIMPLE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INTERP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd2;

endpackage

`default_nettype wire

// File: sv/streaming_histogram_bin_merge.sv
// Streaming histogram top level: bin table, sequencer, shared multiplier and divider.
// Depends on shbm_pkg.
`default_nettype none

// One request is handled at a time; req_stall stays high until its result sits in the
// output register, which may still be waiting while the next request is taken. The bin
// table has one write port and one registered read port, so a search or a shift takes a
// read state and a check or write state per bin, while the closest-pair scan streams one
// bin per cycle. An add scans up to the insertion point and shifts the bins above it, and
// when the table overflows it scans all bins for the closest pair, forms the weighted mean
// with one multiply and a 97-step bit-serial division, then shifts the upper bins down. A
// query scans to the position, runs up to three multiplies on the shared 32x32 multiplier
// and two 97-step divisions (density, then normalization). A read passes through S_READ
// and S_DONE. No clearing pass follows reset.
module streaming_histogram_bin_merge
   import shbm_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [1:0]                req_op,
   input  wire  signed [VAL_W-1:0]   req_value,
   input  wire  [IDX_IN_W-1:0]       req_bin_index,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic                      rsp_empty_res,
   output logic signed [RAW_W-1:0]   rsp_density_raw,
   output logic signed [NORM_W-1:0]  rsp_density_norm,
   output logic signed [VAL_W-1:0]   rsp_bin_center,
   output logic [CNT_W-1:0]          rsp_bin_count,
   output logic [BIN_W-1:0]          rsp_bins_used,
   output logic [CNT_W-1:0]          rsp_total_count,
   input  wire                       csr_write,
   input  wire  [CSR_IDX_W-1:0]      csr_index,
   input  wire  [CSR_DATA_W-1:0]     csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_AFIND_RD, S_AFIND_CHK, S_INS, S_INS_RD, S_INS_WR, S_AFIN,
      S_M0, S_MSCAN, S_MG_RD0, S_MG_RD1, S_MG_CALC, S_MG_MULT, S_MG_START, S_MG_DIV,
      S_MSH_RD, S_MSH_WR, S_READ, S_QFIND_RD, S_QFIND_CHK, S_QONE, S_PDF,
      S_QM1, S_QM2, S_QM3, S_QGO, S_QDIV, S_NDIV, S_DONE
   } state_type;

   localparam logic [CNT_W-1:0]     CNT_MAX  = '1;
   localparam logic [BIN_W-1:0]     DEPTH_B  = BIN_W'(DEPTH);
   localparam logic [BIN_W-1:0]     MAX_B    = BIN_W'(MAX_BINS);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_N_W);

   // Control registers.
   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]        used_ff, used_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic signed [VAL_W-1:0] low_ff, low_in;
   logic signed [VAL_W-1:0] high_ff, high_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   // Output register.
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [RAW_W-1:0]        rsp_raw_ff, rsp_raw_in;
   logic [NORM_W-1:0]       rsp_norm_ff, rsp_norm_in;
   logic [VAL_W-1:0]        rsp_center_ff, rsp_center_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [BIN_W-1:0]        rsp_used_ff, rsp_used_in;
   logic [CNT_W-1:0]        rsp_total_ff, rsp_total_in;

   // Working registers.
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic [BIN_W-1:0]        i_ff, i_in;
   logic [BIN_W-1:0]        pos_ff, pos_in;
   logic [BIN_W-1:0]        best_ff, best_in;
   logic [VAL_W-1:0]        bestd_ff, bestd_in;
   logic signed [VAL_W-1:0] prev_c_ff, prev_c_in;
   logic [CNT_W-1:0]        prev_n_ff, prev_n_in;
   logic signed [VAL_W-1:0] p1_ff, p1_in;
   logic signed [VAL_W-1:0] p2_ff, p2_in;
   logic [CNT_W-1:0]        m1_ff, m1_in;
   logic [CNT_W-1:0]        m2_ff, m2_in;
   logic [VAL_W-1:0]        w_ff, w_in;
   logic [VAL_W-1:0]        opa_ff, opa_in;
   logic [VAL_W-1:0]        opc_ff, opc_in;
   logic [CNT_W:0]          sum_ff, sum_in;
   logic [PROD_W-1:0]       prod1_ff, prod1_in;
   logic [PROD_W:0]         acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic [RAW_W-1:0]        res_raw_ff, res_raw_in;
   logic [NORM_W-1:0]       res_norm_ff, res_norm_in;
   logic [VAL_W-1:0]        res_center_ff, res_center_in;
   logic [CNT_W-1:0]        res_count_ff, res_count_in;
   logic [PROD_W-1:0]       mul_p_ff, mul_p_in;
   logic [DIV_N_W-1:0]      div_num_ff, div_num_in;
   logic [DIV_D_W-1:0]      div_rem_ff, div_rem_in;
   logic [DIV_D_W-1:0]      div_den_ff, div_den_in;

   // Bin table.
   logic [VAL_W-1:0]        center_mem [DEPTH];
   logic [CNT_W-1:0]        count_mem  [DEPTH];
   logic signed [VAL_W-1:0] rd_c_ff;
   logic [CNT_W-1:0]        rd_n_ff;
   logic [BIN_W-1:0]        rd_addr;
   logic                    mem_we;
   logic [BIN_W-1:0]        wr_addr;
   logic [VAL_W-1:0]        wr_c;
   logic [CNT_W-1:0]        wr_n;

   // Shared units.
   logic [VAL_W-1:0]        mul_a, mul_b;
   logic                    div_go;
   logic [DIV_N_W-1:0]      div_go_num;
   logic [DIV_D_W-1:0]      div_go_den;
   logic [DIV_D_W:0]        div_rem_sh, div_diff;
   logic                    div_ge;

   // Derived values.
   logic [BIN_W-1:0]        cap_eff;
   logic signed [VAL_W:0]   w_diff, a_diff, c_diff, scan_diff;
   logic [VAL_W-1:0]        a_val, c_val, abs_p1, abs_p2;
   logic [CNT_W:0]          m_sum;
   logic [PROD_W:0]         s_add;
   logic [PROD_W-1:0]       s_12, s_21;
   logic [RAW_W-1:0]        raw_sat;
   logic [NORM_W-1:0]       norm_sat;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_density_raw  = rsp_raw_ff;
   assign rsp_density_norm = rsp_norm_ff;
   assign rsp_bin_center   = rsp_center_ff;
   assign rsp_bin_count    = rsp_count_ff;
   assign rsp_bins_used    = rsp_used_ff;
   assign rsp_total_count  = rsp_total_ff;

   // Capacity is clamped to the supported range.
   assign cap_eff = (cap_ff < CAP_W'(2)) ? BIN_W'(2) :
                    ((BIN_W'(cap_ff) > MAX_B) ? MAX_B : BIN_W'(cap_ff));

   // Interval width, distances to the query point, and center magnitudes.
   assign w_diff    = {p2_ff[VAL_W-1], p2_ff} - {p1_ff[VAL_W-1], p1_ff};
   assign a_diff    = {p2_ff[VAL_W-1], p2_ff} - {x_ff[VAL_W-1], x_ff};
   assign c_diff    = {x_ff[VAL_W-1], x_ff} - {p1_ff[VAL_W-1], p1_ff};
   assign scan_diff = {rd_c_ff[VAL_W-1], rd_c_ff} - {prev_c_ff[VAL_W-1], prev_c_ff};
   assign a_val  = (p2_ff > x_ff) ? a_diff[VAL_W-1:0] : '0;
   assign c_val  = (x_ff > p1_ff) ? c_diff[VAL_W-1:0] : '0;
   assign abs_p1 = p1_ff[VAL_W-1] ? (~p1_ff + VAL_W'(1)) : p1_ff;
   assign abs_p2 = p2_ff[VAL_W-1] ? (~p2_ff + VAL_W'(1)) : p2_ff;
   assign m_sum  = {1'b0, m1_ff} + {1'b0, m2_ff};

   // Signed combination of the two weighted centers.
   assign s_add = {1'b0, prod1_ff} + {1'b0, mul_p_ff};
   assign s_12  = prod1_ff - mul_p_ff;
   assign s_21  = mul_p_ff - prod1_ff;

   // Saturation of the divider quotient into the two density fields.
   always_comb begin
      if (!neg_ff) begin
         raw_sat  = (|div_num_ff[DIV_N_W-1:RAW_W-1]) ? {1'b0, {(RAW_W-1){1'b1}}}
                                                     : div_num_ff[RAW_W-1:0];
         norm_sat = (|div_num_ff[DIV_N_W-1:NORM_W-1]) ? {1'b0, {(NORM_W-1){1'b1}}}
                                                       : div_num_ff[NORM_W-1:0];
      end else begin
         if ((|div_num_ff[DIV_N_W-1:RAW_W]) ||
             (div_num_ff[RAW_W-1] && (|div_num_ff[RAW_W-2:0]))) begin
            raw_sat = {1'b1, {(RAW_W-1){1'b0}}};
         end else begin
            raw_sat = '0 - div_num_ff[RAW_W-1:0];
         end
         if ((|div_num_ff[DIV_N_W-1:NORM_W]) ||
             (div_num_ff[NORM_W-1] && (|div_num_ff[NORM_W-2:0]))) begin
            norm_sat = {1'b1, {(NORM_W-1){1'b0}}};
         end else begin
            norm_sat = '0 - div_num_ff[NORM_W-1:0];
         end
      end
   end

   // Table read address for the data wanted in the following cycle.
   always_comb begin
      case (state_ff)
         S_IDLE:      rd_addr = BIN_W'(req_bin_index);
         S_INS_RD:    rd_addr = i_ff - BIN_W'(1);
         S_M0:        rd_addr = '0;
         S_MSCAN:     rd_addr = i_ff + BIN_W'(1);
         S_MSH_RD:    rd_addr = i_ff + BIN_W'(1);
         S_MG_RD0:    rd_addr = best_ff;
         S_MG_RD1:    rd_addr = best_ff + BIN_W'(1);
         S_QFIND_CHK: rd_addr = BIN_W'(1);
         default:     rd_addr = i_ff;
      endcase
   end

   // Table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         center_mem[wr_addr] <= wr_c;
         count_mem[wr_addr]  <= wr_n;
      end
      rd_c_ff <= center_mem[rd_addr];
      rd_n_ff <= count_mem[rd_addr];
   end

   // Sequencer, shared multiplier operands and shared divider.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      cap_in        = cap_ff;
      mode_in       = mode_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_norm_in   = rsp_norm_ff;
      rsp_center_in = rsp_center_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_total_in  = rsp_total_ff;
      x_in          = x_ff;
      i_in          = i_ff;
      pos_in        = pos_ff;
      best_in       = best_ff;
      bestd_in      = bestd_ff;
      prev_c_in     = prev_c_ff;
      prev_n_in     = prev_n_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      w_in          = w_ff;
      opa_in        = opa_ff;
      opc_in        = opc_ff;
      sum_in        = sum_ff;
      prod1_in      = prod1_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      res_raw_in    = res_raw_ff;
      res_norm_in   = res_norm_ff;
      res_center_in = res_center_ff;
      res_count_in  = res_count_ff;
      mem_we        = 1'b0;
      wr_addr       = i_ff;
      wr_c          = rd_c_ff;
      wr_n          = rd_n_ff;
      mul_a         = m1_ff;
      mul_b         = opa_ff;
      div_go        = 1'b0;
      div_go_num    = '0;
      div_go_den    = '0;

      // A waiting result leaves when the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_write) begin
         if (csr_index == CSR_CAPACITY) begin
            cap_in = csr_data[CAP_W-1:0];
         end else begin
            mode_in = csr_data[MODE_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in          = req_value;
               i_in          = '0;
               neg_in        = 1'b0;
               res_raw_in    = '0;
               res_norm_in   = '0;
               res_center_in = '0;
               res_count_in  = '0;
               case (op_type'(req_op))
                  OP_ADD:   state_in = S_AFIND_RD;
                  OP_QUERY: state_in = (used_ff == '0) ? S_DONE : S_QFIND_RD;
                  OP_READ:  state_in = (BIN_W'(req_bin_index) < used_ff) ? S_READ : S_DONE;
                  default:  state_in = S_DONE;
               endcase
            end
         end

         // Add: find the first bin whose center is not below the point.
         S_AFIND_RD: begin
            if (i_ff == used_ff) begin
               pos_in   = i_ff;
               state_in = S_INS;
            end else begin
               state_in = S_AFIND_CHK;
            end
         end

         S_AFIND_CHK: begin
            if (rd_c_ff < x_ff) begin
               i_in     = i_ff + BIN_W'(1);
               state_in = S_AFIND_RD;
            end else if (rd_c_ff == x_ff) begin
               mem_we   = 1'b1;
               wr_n     = (rd_n_ff != CNT_MAX) ? rd_n_ff + CNT_W'(1) : rd_n_ff;
               state_in = S_AFIN;
            end else begin
               pos_in   = i_ff;
               state_in = S_INS;
            end
         end

         // Insert: open a slot by moving the upper bins up one place.
         S_INS: begin
            if (used_ff == DEPTH_B) begin
               state_in = S_AFIN;
            end else begin
               i_in     = used_ff;
               state_in = S_INS_RD;
            end
         end

         S_INS_RD: begin
            if (i_ff == pos_ff) begin
               mem_we   = 1'b1;
               wr_addr  = pos_ff;
               wr_c     = x_ff;
               wr_n     = CNT_W'(1);
               used_in  = used_ff + BIN_W'(1);
               state_in = S_AFIN;
            end else begin
               state_in = S_INS_WR;
            end
         end

         S_INS_WR: begin
            mem_we   = 1'b1;
            i_in     = i_ff - BIN_W'(1);
            state_in = S_INS_RD;
         end

         // Totals and extremes; start a merge when the table overflows.
         S_AFIN: begin
            if (total_ff != CNT_MAX) begin
               total_in = total_ff + CNT_W'(1);
            end
            if (x_ff < low_ff) begin
               low_in = x_ff;
            end
            if (x_ff > high_ff) begin
               high_in = x_ff;
            end
            state_in = (used_ff > cap_eff) ? S_M0 : S_DONE;
         end

         // Merge: scan neighbor distances, keeping the leftmost smallest.
         S_M0: begin
            i_in     = '0;
            state_in = S_MSCAN;
         end

         S_MSCAN: begin
            prev_c_in = rd_c_ff;
            if (i_ff != '0) begin
               if ((i_ff == BIN_W'(1)) || (scan_diff[VAL_W-1:0] < bestd_ff)) begin
                  bestd_in = scan_diff[VAL_W-1:0];
                  best_in  = i_ff - BIN_W'(1);
               end
            end
            if (i_ff == used_ff - BIN_W'(1)) begin
               state_in = S_MG_RD0;
            end else begin
               i_in = i_ff + BIN_W'(1);
            end
         end

         S_MG_RD0: begin
            state_in = S_MG_RD1;
         end

         S_MG_RD1: begin
            p1_in    = rd_c_ff;
            m1_in    = rd_n_ff;
            state_in = S_MG_CALC;
         end

         S_MG_CALC: begin
            m2_in    = rd_n_ff;
            w_in     = rd_c_ff - p1_ff;
            sum_in   = {1'b0, m1_ff} + {1'b0, rd_n_ff};
            state_in = S_MG_MULT;
         end

         S_MG_MULT: begin
            mul_a    = w_ff;
            mul_b    = m2_ff;
            state_in = S_MG_START;
         end

         S_MG_START: begin
            div_go     = 1'b1;
            div_go_num = DIV_N_W'(mul_p_ff);
            div_go_den = DIV_D_W'(sum_ff);
            state_in   = S_MG_DIV;
         end

         // Write the merged bin, then close the gap above it.
         S_MG_DIV: begin
            if (div_cnt_ff == '0) begin
               mem_we   = 1'b1;
               wr_addr  = best_ff;
               wr_c     = p1_ff + div_num_ff[VAL_W-1:0];
               wr_n     = sum_ff[CNT_W] ? CNT_MAX : sum_ff[CNT_W-1:0];
               i_in     = best_ff + BIN_W'(1);
               state_in = S_MSH_RD;
            end
         end

         S_MSH_RD: begin
            if (i_ff == used_ff - BIN_W'(1)) begin
               used_in  = used_ff - BIN_W'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_MSH_WR;
            end
         end

         S_MSH_WR: begin
            mem_we   = 1'b1;
            i_in     = i_ff + BIN_W'(1);
            state_in = S_MSH_RD;
         end

         // Read of one bin.
         S_READ: begin
            res_center_in = rd_c_ff;
            res_count_in  = rd_n_ff;
            state_in      = S_DONE;
         end

         // Query: find the bins around the position.
         S_QFIND_RD: begin
            if (i_ff == used_ff) begin
               if (x_ff > high_ff) begin
                  state_in = S_DONE;
               end else begin
                  p1_in    = prev_c_ff;
                  m1_in    = prev_n_ff;
                  p2_in    = high_ff;
                  m2_in    = '0;
                  state_in = S_PDF;
               end
            end else begin
               state_in = S_QFIND_CHK;
            end
         end

         S_QFIND_CHK: begin
            if (rd_c_ff < x_ff) begin
               prev_c_in = rd_c_ff;
               prev_n_in = rd_n_ff;
               i_in      = i_ff + BIN_W'(1);
               state_in  = S_QFIND_RD;
            end else if (i_ff != '0) begin
               p1_in    = prev_c_ff;
               m1_in    = prev_n_ff;
               p2_in    = rd_c_ff;
               m2_in    = rd_n_ff;
               state_in = S_PDF;
            end else if (x_ff < low_ff) begin
               state_in = S_DONE;
            end else if (x_ff == rd_c_ff) begin
               if (used_ff == BIN_W'(1)) begin
                  // A lone bin at the position gives its own count.
                  div_go     = 1'b1;
                  div_go_num = DIV_N_W'(rd_n_ff) << FRAC_BITS;
                  div_go_den = DIV_D_W'(1);
                  state_in   = S_QDIV;
               end else begin
                  p1_in    = rd_c_ff;
                  m1_in    = rd_n_ff;
                  state_in = S_QONE;
               end
            end else begin
               p1_in    = low_ff;
               m1_in    = '0;
               p2_in    = rd_c_ff;
               m2_in    = rd_n_ff;
               state_in = S_PDF;
            end
         end

         S_QONE: begin
            p2_in    = rd_c_ff;
            m2_in    = rd_n_ff;
            state_in = S_PDF;
         end

         // Density formula setup.
         S_PDF: begin
            if (w_diff[VAL_W] || (w_diff == '0)) begin
               state_in = S_DONE;
            end else begin
               w_in = w_diff[VAL_W-1:0];
               if (mode_ff == MODE_INTERP) begin
                  opa_in   = a_val;
                  opc_in   = c_val;
                  state_in = S_QM1;
               end else if (mode_ff == MODE_WEIGHTED) begin
                  opa_in   = abs_p1;
                  opc_in   = abs_p2;
                  state_in = S_QM1;
               end else begin
                  div_go     = 1'b1;
                  div_go_num = DIV_N_W'(m_sum) << (2 * FRAC_BITS);
                  div_go_den = DIV_D_W'({w_diff[VAL_W-1:0], 1'b0});
                  state_in   = S_QDIV;
               end
            end
         end

         S_QM1: begin
            state_in = S_QM2;
         end

         S_QM2: begin
            prod1_in = mul_p_ff;
            mul_a    = m2_ff;
            mul_b    = opc_ff;
            state_in = S_QM3;
         end

         S_QM3: begin
            if (mode_ff == MODE_INTERP) begin
               acc_in   = s_add;
               mul_a    = w_ff;
               mul_b    = w_ff;
               state_in = S_QGO;
            end else begin
               // Weighted centers with opposite signs partly cancel.
               if (p1_ff[VAL_W-1] == p2_ff[VAL_W-1]) begin
                  div_go_num = DIV_N_W'(s_add) << FRAC_BITS;
                  neg_in     = p1_ff[VAL_W-1];
               end else if (prod1_ff >= mul_p_ff) begin
                  div_go_num = DIV_N_W'(s_12) << FRAC_BITS;
                  neg_in     = p1_ff[VAL_W-1];
               end else begin
                  div_go_num = DIV_N_W'(s_21) << FRAC_BITS;
                  neg_in     = p2_ff[VAL_W-1];
               end
               div_go     = 1'b1;
               div_go_den = DIV_D_W'({w_ff, 1'b0});
               state_in   = S_QDIV;
            end
         end

         S_QGO: begin
            div_go     = 1'b1;
            div_go_num = DIV_N_W'(acc_ff) << (2 * FRAC_BITS);
            div_go_den = mul_p_ff;
            state_in   = S_QDIV;
         end

         // Raw density, then normalization of the full quotient by the total.
         S_QDIV: begin
            if (div_cnt_ff == '0) begin
               res_raw_in = raw_sat;
               if (total_ff != '0) begin
                  div_go     = 1'b1;
                  div_go_num = div_num_ff;
                  div_go_den = DIV_D_W'(total_ff);
                  state_in   = S_NDIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_NDIV: begin
            if (div_cnt_ff == '0) begin
               res_norm_in = norm_sat;
               state_in    = S_DONE;
            end
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_empty_in  = (used_ff == '0);
               rsp_raw_in    = res_raw_ff;
               rsp_norm_in   = res_norm_ff;
               rsp_center_in = res_center_ff;
               rsp_count_in  = res_count_ff;
               rsp_used_in   = used_ff;
               rsp_total_in  = total_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Restoring divider step: one quotient bit per cycle.
   assign div_rem_sh = {div_rem_ff, div_num_ff[DIV_N_W-1]};
   assign div_ge     = (div_rem_sh >= {1'b0, div_den_ff});
   assign div_diff   = div_rem_sh - {1'b0, div_den_ff};

   always_comb begin
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (div_go) begin
         div_num_in = div_go_num;
         div_rem_in = '0;
         div_den_in = div_go_den;
         div_cnt_in = DIV_STEPS;
      end else if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? div_diff[DIV_D_W-1:0] : div_rem_sh[DIV_D_W-1:0];
         div_num_in = {div_num_ff[DIV_N_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   // Shared 32x32 multiplier with registered product.
   assign mul_p_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         total_ff     <= '0;
         low_ff       <= {1'b0, {(VAL_W-1){1'b1}}};
         high_ff      <= {1'b1, {(VAL_W-1){1'b0}}};
         cap_ff       <= CAP_W'(MAX_BINS);
         mode_ff      <= MODE_SIMPLE;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         cap_ff       <= cap_in;
         mode_ff      <= mode_in;
         div_cnt_ff   <= div_cnt_in;
      end
      rsp_empty_ff  <= rsp_empty_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_norm_ff   <= rsp_norm_in;
      rsp_center_ff <= rsp_center_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_total_ff  <= rsp_total_in;
      x_ff          <= x_in;
      i_ff          <= i_in;
      pos_ff        <= pos_in;
      best_ff       <= best_in;
      bestd_ff      <= bestd_in;
      prev_c_ff     <= prev_c_in;
      prev_n_ff     <= prev_n_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      w_ff          <= w_in;
      opa_ff        <= opa_in;
      opc_ff        <= opc_in;
      sum_ff        <= sum_in;
      prod1_ff      <= prod1_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      res_raw_ff    <= res_raw_in;
      res_norm_ff   <= res_norm_in;
      res_center_ff <= res_center_in;
      res_count_ff  <= res_count_in;
      mul_p_ff      <= mul_p_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_den_ff    <= div_den_in;
   end

endmodule

`default_nettype wire
